// ===== rtl/lqd_pkg.sv =====
// shared constants, types and helpers for the linked queue with deadline expiry
package lqd_pkg;

  localparam int ENTRIES = 32;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int VIS_W = $clog2(ENTRIES + 1);
  localparam int ID_W = 5;
  localparam int TW = 16;
  localparam int CNT_W = 5;
  localparam logic [TW-1:0] SPAN_MAX = 16'd60000;
  localparam logic [CNT_W-1:0] MAX_REMOVED = 5'd31;

  typedef enum logic [1:0] {
    CMD_PULL   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_EXPIRE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PULL,
    ST_APPEND,
    ST_FIN,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_EXP_END
  } state_t;

  // verdict of the shared remaining-time unit
  typedef struct packed {
    logic          expired;
    logic [TW-1:0] limit;
  } remain_t;

  function automatic logic id_ok(input logic [ID_W-1:0] id);
    return (id != '0) && ({4'b0, id} < 9'(ENTRIES));
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [ID_W-1:0] id);
    return AW'(id);
  endfunction

endpackage

// ===== rtl/lqd_ram.sv =====
// generic single-write, single-read memory with registered read data
module lqd_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lqd_remain.sv =====
// remaining-time unit: modular difference, expiry test and running minimum
module lqd_remain (
  input  logic [lqd_pkg::TW-1:0] deadline,
  input  logic [lqd_pkg::TW-1:0] now_ms,
  input  logic [lqd_pkg::TW-1:0] limit,
  output lqd_pkg::remain_t       verdict
);
  import lqd_pkg::*;

  logic [TW-1:0] remain;

  always_comb begin
    remain = deadline - now_ms;
    verdict.expired = (remain == '0) || (remain > SPAN_MAX);
    verdict.limit = (limit > remain) ? remain : limit;
  end

endmodule

// ===== rtl/linked_queue_with_deadline_expiry.sv =====
// top level: linked-list queue sequencer with deadline expiry walk
//
// One command is taken at a time; in_stall is high from acceptance until the
// command's final word has been loaded into the output register. Pull uses
// ST_PULL, insert ST_FIN, append ST_APPEND and ST_FIN (two writes through the
// single write port of the link memory); expire visits each entry through
// ST_EXP_RD and ST_EXP_CHK (one registered read of the link and deadline
// memories, then one pass through the shared remaining-time unit) and ends in
// ST_EXP_END. The memories are not cleared after reset.
module linked_queue_with_deadline_expiry (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_command,
  input  logic [lqd_pkg::ID_W-1:0]  in_entry_id,
  input  logic [lqd_pkg::TW-1:0]    in_deadline,
  input  logic [lqd_pkg::TW-1:0]    in_now_ms,
  input  logic [lqd_pkg::TW-1:0]    in_limit_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lqd_pkg::ID_W-1:0]  out_result_id,
  output logic [lqd_pkg::TW-1:0]    out_limit_out,
  output logic [lqd_pkg::CNT_W-1:0] out_expired_count,
  output logic                      out_last
);
  import lqd_pkg::*;

  state_t state_r, state_nxt;
  cmd_t   cmd_in;

  logic [ID_W-1:0]  id_r, id_nxt;
  logic [TW-1:0]    now_r, now_nxt;
  logic [TW-1:0]    limit_r, limit_nxt;
  logic [ID_W-1:0]  head_r, head_nxt;
  logic [ID_W-1:0]  tail_r, tail_nxt;
  logic [ID_W-1:0]  prev_r, prev_nxt;
  logic [ID_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0] removed_r, removed_nxt;
  logic [VIS_W-1:0] visits_r, visits_nxt;

  logic             out_valid_r;
  logic [ID_W-1:0]  out_id_r;
  logic [TW-1:0]    out_lim_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_last_r;

  logic             accept;
  logic             out_free;
  logic             walk_done;
  logic             emit;
  logic [ID_W-1:0]  emit_id;
  logic [TW-1:0]    emit_lim;
  logic [CNT_W-1:0] emit_cnt;
  logic             emit_last;

  logic             lk_we, lk_re, dl_we, dl_re;
  logic [AW-1:0]    lk_waddr, lk_raddr, dl_waddr, dl_raddr;
  logic [ID_W-1:0]  lk_wdata, lk_rdata;
  logic [TW-1:0]    dl_wdata, dl_rdata;
  remain_t          verdict;

  lqd_ram #(.DEPTH(ENTRIES), .WIDTH(ID_W)) u_link (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  lqd_ram #(.DEPTH(ENTRIES), .WIDTH(TW)) u_deadline (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .re    (dl_re),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  lqd_remain u_remain (
    .deadline (dl_rdata),
    .now_ms   (now_r),
    .limit    (limit_r),
    .verdict  (verdict)
  );

  assign cmd_in    = cmd_t'(in_command);
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign walk_done = (cur_r == '0) || (visits_r == VIS_W'(ENTRIES)) ||
                     (removed_r == MAX_REMOVED);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_in)
            CMD_PULL:   state_nxt = ST_PULL;
            CMD_INSERT: state_nxt = ST_FIN;
            CMD_APPEND: state_nxt = ST_APPEND;
            CMD_EXPIRE: state_nxt = ST_EXP_RD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PULL:    if (out_free) state_nxt = ST_IDLE;
      ST_APPEND:  state_nxt = ST_FIN;
      ST_FIN:     if (out_free) state_nxt = ST_IDLE;
      ST_EXP_RD:  state_nxt = walk_done ? ST_EXP_END : ST_EXP_CHK;
      ST_EXP_CHK: begin
        if (!verdict.expired || out_free) state_nxt = ST_EXP_RD;
      end
      ST_EXP_END: if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // memory controls, result words and datapath updates
  always_comb begin
    lk_we = 1'b0; lk_waddr = '0; lk_wdata = '0;
    lk_re = 1'b0; lk_raddr = '0;
    dl_we = 1'b0; dl_waddr = '0; dl_wdata = '0;
    dl_re = 1'b0; dl_raddr = '0;
    emit = 1'b0; emit_id = '0; emit_lim = '0; emit_cnt = '0; emit_last = 1'b0;
    id_nxt = id_r; now_nxt = now_r; limit_nxt = limit_r;
    head_nxt = head_r; tail_nxt = tail_r;
    prev_nxt = prev_r; cur_nxt = cur_r;
    removed_nxt = removed_r; visits_nxt = visits_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          id_nxt = in_entry_id;
          now_nxt = in_now_ms;
          limit_nxt = in_limit_in;
          case (cmd_in)
            CMD_PULL: begin
              lk_re = 1'b1;
              lk_raddr = to_addr(head_r);
            end
            CMD_INSERT: begin
              if (id_ok(in_entry_id)) begin
                lk_we = 1'b1;
                lk_waddr = to_addr(in_entry_id);
                lk_wdata = head_r;
                head_nxt = in_entry_id;
                if (tail_r == '0) tail_nxt = in_entry_id;
              end
            end
            CMD_APPEND: begin
              if (id_ok(in_entry_id)) begin
                dl_we = 1'b1;
                dl_waddr = to_addr(in_entry_id);
                dl_wdata = in_deadline;
                lk_we = 1'b1;
                lk_waddr = to_addr(in_entry_id);
                lk_wdata = '0;
              end
            end
            CMD_EXPIRE: begin
              prev_nxt = '0;
              cur_nxt = head_r;
              removed_nxt = '0;
              visits_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_PULL: begin
        if (out_free) begin
          emit = 1'b1;
          emit_id = head_r;
          emit_last = 1'b1;
          if (head_r != '0) begin
            head_nxt = lk_rdata;
            if (lk_rdata == '0) tail_nxt = '0;
            lk_we = 1'b1;
            lk_waddr = to_addr(head_r);
            lk_wdata = '0;
          end
        end
      end
      ST_APPEND: begin
        // second link write: old tail points at the new word
        if (id_ok(id_r)) begin
          if (tail_r != '0) begin
            lk_we = 1'b1;
            lk_waddr = to_addr(tail_r);
            lk_wdata = id_r;
          end
          tail_nxt = id_r;
          if (head_r == '0) head_nxt = id_r;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          emit_last = 1'b1;
        end
      end
      ST_EXP_RD: begin
        if (!walk_done) begin
          lk_re = 1'b1;
          lk_raddr = to_addr(cur_r);
          dl_re = 1'b1;
          dl_raddr = to_addr(cur_r);
        end
      end
      ST_EXP_CHK: begin
        if (verdict.expired) begin
          if (out_free) begin
            emit = 1'b1;
            emit_id = cur_r;
            if (tail_r == cur_r) tail_nxt = prev_r;
            if (prev_r == '0) begin
              head_nxt = lk_rdata;
            end else begin
              lk_we = 1'b1;
              lk_waddr = to_addr(prev_r);
              lk_wdata = lk_rdata;
            end
            removed_nxt = removed_r + 1'b1;
            cur_nxt = lk_rdata;
            visits_nxt = visits_r + 1'b1;
          end
        end else begin
          limit_nxt = verdict.limit;
          prev_nxt = cur_r;
          cur_nxt = lk_rdata;
          visits_nxt = visits_r + 1'b1;
        end
      end
      ST_EXP_END: begin
        if (out_free) begin
          emit = 1'b1;
          emit_lim = limit_r;
          emit_cnt = removed_r;
          emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r <= '0;
      tail_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    now_r <= now_nxt;
    limit_r <= limit_nxt;
    prev_r <= prev_nxt;
    cur_r <= cur_nxt;
    removed_r <= removed_nxt;
    visits_r <= visits_nxt;
    if (emit) begin
      out_id_r <= emit_id;
      out_lim_r <= emit_lim;
      out_cnt_r <= emit_cnt;
      out_last_r <= emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_result_id = out_id_r;
  assign out_limit_out = out_lim_r;
  assign out_expired_count = out_cnt_r;
  assign out_last = out_last_r;

endmodule
